FILE: rtl/mtsp_pkg.sv
// Shared types and constants for the MADT table stream parser.
// Item structs, walk event, status and commit view structs, command and entry type codes, signature bytes.
// No dependencies.
package mtsp_pkg;

    localparam int ISA_IRQ_COUNT     = 16;
    localparam int IRQ_W             = $clog2(ISA_IRQ_COUNT);
    localparam int MADT_HEADER_BYTES = 44;

    localparam logic CMD_TABLE_BYTE = 1'b0;
    localparam logic CMD_LOOKUP     = 1'b1;

    localparam logic [7:0] TYPE_LOCAL_APIC   = 8'd0;
    localparam logic [7:0] TYPE_IO_APIC      = 8'd1;
    localparam logic [7:0] TYPE_SRC_OVERRIDE = 8'd2;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       data_byte;
        logic             last;
        logic [IRQ_W-1:0] isa_irq;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  mapped_vector;
        logic        table_done;
        logic        table_accepted;
        logic        checksum_ok;
        logic        is_madt;
        logic [15:0] cpu_count;
        logic [31:0] ioapic_base;
        logic        ioapic_found;
        logic        multiple_ioapic;
        logic        bad_entry_length;
    } t_out_item;

    typedef struct packed {
        logic             table_start;
        logic             cpu_entry;
        logic             ioapic_hit;
        logic [31:0]      ioapic_base;
        logic             ovr_hit;
        logic [IRQ_W-1:0] ovr_irq;
        logic [7:0]       ovr_vector;
        logic             commit;
    } t_walk_ev;

    typedef struct packed {
        logic done;
        logic accepted;
        logic sum_ok;
        logic madt;
        logic bad;
    } t_walk_status;

    typedef struct packed {
        logic [15:0] cpu_count;
        logic [31:0] ioapic_base;
        logic        ioapic_found;
        logic        multiple;
    } t_commit_view;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h41;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h49;
            default: b = 8'h43;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/mtsp_in_stage.sv
// Input register of the parser: holds one accepted beat until the work stage takes it.
// Depends on mtsp_pkg.
module mtsp_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mtsp_pkg::t_in_item  i_item,
    input  logic                i_advance,
    output logic                o_s1_valid,
    output mtsp_pkg::t_in_item  o_s1_item
);
    import mtsp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready    = !r_valid || i_advance;
    assign o_s1_valid = r_valid;
    assign o_s1_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/mtsp_table_walker.sv
// Per-table byte walker: offset, checksum, signature, length and MADT entry tracking.
// Emits walk events toward the result store. Depends on mtsp_pkg.
module mtsp_table_walker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic                   i_byte_en,
    input  mtsp_pkg::t_in_item     i_item,
    output mtsp_pkg::t_walk_ev     o_ev,
    output mtsp_pkg::t_walk_status o_status
);
    import mtsp_pkg::*;

    logic [31:0] r_byte_offset, n_byte_offset;
    logic [7:0]  r_byte_sum, n_byte_sum;
    logic        r_sig_match, n_sig_match;
    logic [31:0] r_table_length, n_table_length;
    logic [31:0] r_entry_start, n_entry_start;
    logic [7:0]  r_entry_type, n_entry_type;
    logic [7:0]  r_entry_length, n_entry_length;
    logic [7:0]  r_entry_bus, n_entry_bus;
    logic [7:0]  r_entry_src, n_entry_src;
    logic [31:0] r_entry_word, n_entry_word;
    logic        r_parse_stopped, n_parse_stopped;

    logic [31:0] rel;
    logic        active;
    logic [7:0]  b;

    assign b      = i_item.data_byte;
    assign rel    = r_byte_offset - r_entry_start;
    assign active = !r_parse_stopped
                    && (r_byte_offset >= 32'(MADT_HEADER_BYTES))
                    && (r_byte_offset >= r_entry_start)
                    && (r_entry_start < r_table_length);

    always_comb begin
        logic        end_chk;
        logic [31:0] word_new;
        logic [32:0] es_sum;
        end_chk         = 1'b0;
        word_new        = r_entry_word;
        es_sum          = '0;
        n_byte_offset   = r_byte_offset;
        n_byte_sum      = r_byte_sum;
        n_sig_match     = r_sig_match;
        n_table_length  = r_table_length;
        n_entry_start   = r_entry_start;
        n_entry_type    = r_entry_type;
        n_entry_length  = r_entry_length;
        n_entry_bus     = r_entry_bus;
        n_entry_src     = r_entry_src;
        n_entry_word    = r_entry_word;
        n_parse_stopped = r_parse_stopped;
        o_ev            = '0;
        o_status        = '0;
        if (i_byte_en) begin
            o_ev.table_start = (r_byte_offset == 32'd0);
            n_byte_sum = r_byte_sum + b;
            if (r_byte_offset < 32'd4) begin
                if (b != sig_byte(r_byte_offset[1:0])) begin
                    n_sig_match = 1'b0;
                end
            end else if (r_byte_offset < 32'd8) begin
                n_table_length = r_table_length
                                 | ({24'd0, b} << {r_byte_offset[1:0], 3'b000});
            end
            if (active) begin
                end_chk = 1'b1;
                if (rel == 32'd0) begin
                    n_entry_type = b;
                    n_entry_word = '0;
                    end_chk      = 1'b0;
                end else if (rel == 32'd1) begin
                    n_entry_length = b;
                    if (b < 8'd2) begin
                        n_parse_stopped = 1'b1;
                        end_chk         = 1'b0;
                    end else if (r_entry_type == TYPE_LOCAL_APIC) begin
                        o_ev.cpu_entry = 1'b1;
                    end
                end else if (rel == 32'd2) begin
                    n_entry_bus = b;
                end else if (rel == 32'd3) begin
                    n_entry_src = b;
                end else if (rel < 32'd8) begin
                    word_new     = r_entry_word | ({24'd0, b} << {rel[1:0], 3'b000});
                    n_entry_word = word_new;
                    if (rel == 32'd7) begin
                        if (r_entry_type == TYPE_IO_APIC) begin
                            o_ev.ioapic_hit  = 1'b1;
                            o_ev.ioapic_base = word_new;
                        end else if (r_entry_type == TYPE_SRC_OVERRIDE
                                     && r_entry_bus == 8'd0
                                     && r_entry_src < 8'(ISA_IRQ_COUNT)) begin
                            o_ev.ovr_hit    = 1'b1;
                            o_ev.ovr_irq    = r_entry_src[IRQ_W-1:0];
                            o_ev.ovr_vector = word_new[7:0];
                        end
                    end
                end
                if (end_chk && (rel + 32'd1 == {24'd0, n_entry_length})) begin
                    es_sum        = {1'b0, r_entry_start} + {25'd0, n_entry_length};
                    n_entry_start = es_sum[32] ? '1 : es_sum[31:0];
                end
            end
            if (r_byte_offset != '1) begin
                n_byte_offset = r_byte_offset + 32'd1;
            end
            o_status.done     = i_item.last;
            o_status.accepted = i_item.last && (r_byte_offset >= 32'd3)
                                && n_sig_match && (n_byte_sum == 8'd0);
            o_ev.commit       = o_status.accepted;
        end
        o_status.sum_ok = (n_byte_sum == 8'd0);
        o_status.madt   = n_sig_match;
        o_status.bad    = n_parse_stopped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_byte_en && i_item.last)) begin
            r_byte_offset   <= '0;
            r_byte_sum      <= '0;
            r_sig_match     <= 1'b1;
            r_table_length  <= '0;
            r_entry_start   <= 32'(MADT_HEADER_BYTES);
            r_entry_type    <= '0;
            r_entry_length  <= '0;
            r_entry_bus     <= '0;
            r_entry_src     <= '0;
            r_entry_word    <= '0;
            r_parse_stopped <= 1'b0;
        end else if (i_fire && i_byte_en) begin
            r_byte_offset   <= n_byte_offset;
            r_byte_sum      <= n_byte_sum;
            r_sig_match     <= n_sig_match;
            r_table_length  <= n_table_length;
            r_entry_start   <= n_entry_start;
            r_entry_type    <= n_entry_type;
            r_entry_length  <= n_entry_length;
            r_entry_bus     <= n_entry_bus;
            r_entry_src     <= n_entry_src;
            r_entry_word    <= n_entry_word;
            r_parse_stopped <= n_parse_stopped;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_byte_en && i_item.last |=> r_byte_offset == '0 && r_byte_sum == '0
        && r_entry_start == 32'(MADT_HEADER_BYTES))
        else $error("table state not cleared after last beat");
    a_offset_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_byte_en) |=> $stable(r_byte_offset))
        else $error("byte offset moved without a table beat");
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_en && r_parse_stopped |-> !(o_ev.cpu_entry || o_ev.ioapic_hit || o_ev.ovr_hit))
        else $error("entry event after parsing stopped");
`endif

endmodule

FILE: rtl/mtsp_result_store.sv
// Staged and committed MADT results: cpu count, IO APIC address, ISA vector maps.
// Applies walk events, commits on an accepted table, serves lookups. Depends on mtsp_pkg.
module mtsp_result_store (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_fire,
    input  mtsp_pkg::t_walk_ev                    i_ev,
    input  logic [mtsp_pkg::IRQ_W-1:0]            i_isa_irq,
    output logic [7:0]                            o_lookup,
    output mtsp_pkg::t_commit_view                o_view
);
    import mtsp_pkg::*;

    logic [15:0] r_s_cnt, n_s_cnt, r_c_cnt, n_c_cnt;
    logic [31:0] r_s_addr, n_s_addr, r_c_addr, n_c_addr;
    logic        r_s_found, n_s_found, r_c_found, n_c_found;
    logic        r_multiple, n_multiple;
    logic [7:0]  r_s_map [ISA_IRQ_COUNT];
    logic [7:0]  n_s_map [ISA_IRQ_COUNT];
    logic [7:0]  r_c_map [ISA_IRQ_COUNT];
    logic [7:0]  n_c_map [ISA_IRQ_COUNT];

    always_comb begin
        logic [15:0] base_cnt;
        logic [31:0] base_addr;
        logic        base_found;
        base_cnt   = i_ev.table_start ? r_c_cnt : r_s_cnt;
        base_addr  = i_ev.table_start ? r_c_addr : r_s_addr;
        base_found = i_ev.table_start ? r_c_found : r_s_found;
        n_s_cnt    = (i_ev.cpu_entry && base_cnt != '1) ? base_cnt + 16'd1 : base_cnt;
        n_s_addr   = base_addr;
        n_s_found  = base_found;
        n_multiple = r_multiple;
        if (i_ev.ioapic_hit) begin
            if (base_found) begin
                n_multiple = 1'b1;
            end else begin
                n_s_addr  = i_ev.ioapic_base;
                n_s_found = 1'b1;
            end
        end
        for (int i = 0; i < ISA_IRQ_COUNT; i++) begin
            n_s_map[i] = i_ev.table_start ? r_c_map[i] : r_s_map[i];
            if (i_ev.ovr_hit && i_ev.ovr_irq == IRQ_W'(i)) begin
                n_s_map[i] = i_ev.ovr_vector;
            end
            n_c_map[i] = i_ev.commit ? n_s_map[i] : r_c_map[i];
        end
        n_c_cnt   = i_ev.commit ? n_s_cnt : r_c_cnt;
        n_c_addr  = i_ev.commit ? n_s_addr : r_c_addr;
        n_c_found = i_ev.commit ? n_s_found : r_c_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_cnt    <= '0;
            r_s_addr   <= '0;
            r_s_found  <= 1'b0;
            r_c_cnt    <= '0;
            r_c_addr   <= '0;
            r_c_found  <= 1'b0;
            r_multiple <= 1'b0;
            for (int i = 0; i < ISA_IRQ_COUNT; i++) begin
                r_s_map[i] <= 8'(i);
                r_c_map[i] <= 8'(i);
            end
        end else if (i_fire) begin
            r_s_cnt    <= n_s_cnt;
            r_s_addr   <= n_s_addr;
            r_s_found  <= n_s_found;
            r_c_cnt    <= n_c_cnt;
            r_c_addr   <= n_c_addr;
            r_c_found  <= n_c_found;
            r_multiple <= n_multiple;
            for (int i = 0; i < ISA_IRQ_COUNT; i++) begin
                r_s_map[i] <= n_s_map[i];
                r_c_map[i] <= n_c_map[i];
            end
        end
    end

    assign o_lookup            = r_c_map[i_isa_irq];
    assign o_view.cpu_count    = n_c_cnt;
    assign o_view.ioapic_base  = n_c_addr;
    assign o_view.ioapic_found = n_c_found;
    assign o_view.multiple     = n_multiple;

endmodule

FILE: rtl/madt_table_stream_parser_unit.sv
// MADT table stream parser, top level.
// Usage:
//   Input channel (i_valid / o_ready / i_item) carries one beat per table byte, or a
//   lookup of the committed ISA vector map. Output channel (o_valid / i_ready /
//   o_result) returns exactly one result beat per input beat, in order.
//   A table is streamed byte by byte with last set on its final byte; at that beat
//   the staged cpu count, IO APIC address and vector map are committed if the
//   signature is APIC and the byte sum is zero.
// Timing:
//   A result beat passes through the input register, then the result register, after its
//   input beat is accepted; a low i_ready can hold it in either register.
//   Throughput is one beat per cycle unless i_ready stalls the output; each beat updates
//   the walker and the result store in the single stage between the two registers.
// Reset:
//   Synchronous active-low reset empties both registers, clears the per-table state
//   and sets both vector maps to identity. No clearing pass is needed.
// Backpressure:
//   When i_ready is low the result register holds, the input register fills, and
//   o_ready drops; nothing is dropped or repeated.
// Depends on mtsp_pkg, mtsp_in_stage, mtsp_table_walker, mtsp_result_store.
module madt_table_stream_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mtsp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output mtsp_pkg::t_out_item o_result
);
    import mtsp_pkg::*;

    logic         s1_valid;
    t_in_item     s1_item;
    logic         s1_adv;
    logic         fire;
    logic         byte_en;
    t_walk_ev     ev;
    t_walk_status status;
    logic [7:0]   lookup;
    t_commit_view view;
    t_out_item    n_result;
    logic         r_out_valid;
    t_out_item    r_result;

    assign s1_adv  = !r_out_valid || i_ready;
    assign fire    = s1_valid && s1_adv;
    assign byte_en = s1_valid && (s1_item.cmd == CMD_TABLE_BYTE);

    mtsp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .i_advance  (s1_adv),
        .o_s1_valid (s1_valid),
        .o_s1_item  (s1_item)
    );

    mtsp_table_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte_en (byte_en),
        .i_item    (s1_item),
        .o_ev      (ev),
        .o_status  (status)
    );

    mtsp_result_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_ev      (ev),
        .i_isa_irq (s1_item.isa_irq),
        .o_lookup  (lookup),
        .o_view    (view)
    );

    always_comb begin
        n_result                  = '0;
        n_result.mapped_vector    = (s1_item.cmd == CMD_LOOKUP) ? lookup : 8'd0;
        n_result.table_done       = status.done;
        n_result.table_accepted   = status.accepted;
        n_result.checksum_ok      = status.sum_ok;
        n_result.is_madt          = status.madt;
        n_result.cpu_count        = view.cpu_count;
        n_result.ioapic_base      = view.ioapic_base;
        n_result.ioapic_found     = view.ioapic_found;
        n_result.multiple_ioapic  = view.multiple;
        n_result.bad_entry_length = status.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

`ifndef NO_ASSERTIONS
    a_accept_implies_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.table_accepted |->
        o_result.table_done && o_result.checksum_ok && o_result.is_madt)
        else $error("table accepted without passing checks");
    a_done_no_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.table_done |-> o_result.mapped_vector == 8'd0)
        else $error("table byte beat carries a mapped vector");
    a_addr_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.ioapic_found |-> o_result.ioapic_base == '0)
        else $error("IO APIC address committed without found flag");
`endif

endmodule

FILE: test/madt_table_stream_parser_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for madt_table_stream_parser_unit: streams directed and randomized
// ACPI tables mixed with vector lookups, predicts every result beat and compares it.
// Depends on mtsp_pkg and the parser RTL.
module madt_table_stream_parser_unit_tb;
    import mtsp_pkg::*;

    localparam logic [31:0] MADT_SIG     = "APIC";
    localparam int          RANDOM_BEATS = 2000;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          IDLE_PCT     = 29;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          HOLD_START   = 2000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_FROM   = 600;
    localparam int          QUIET_TO     = 1300;
    localparam int          PRINT_CAP    = 40;
    localparam int          LAPIC_LEN    = 8;
    localparam int          IOAPIC_LEN   = 12;
    localparam int          OVR_LEN      = 10;

    typedef enum int {
        TBL_CLEAN, TBL_BAD_SUM, TBL_BAD_SIG, TBL_BAD_LENGTH, TBL_CUT_SHORT,
        TBL_SHORT_LENGTH, TBL_TRAILING, TBL_NOISE, TBL_EVERY_ENTRY
    } t_table_flavor;
    localparam int NUM_FLAVORS = 9;

    typedef enum int {
        ENT_LOCAL_APIC, ENT_IO_APIC, ENT_OVR_ISA, ENT_OVR_HIGH_IRQ, ENT_OVR_OTHER_BUS,
        ENT_SHORT, ENT_OTHER_TYPE, ENT_BAD_LENGTH
    } t_entry_kind;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_result;

    t_in_item    beat_backlog[$];
    t_out_item   parser_results[$];
    logic [7:0]  madt_bytes[$];
    t_out_item   next_result;
    t_out_item   want_result;

    int unsigned cyc         = 0;
    int unsigned hold_left   = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;
    logic        quiet;

    // per-table walk state
    logic [31:0] tbl_offset;
    logic [7:0]  tbl_sum;
    logic        sig_ok;
    logic [31:0] tbl_len;
    logic [31:0] ent_start;
    logic [7:0]  ent_type;
    logic [7:0]  ent_len;
    logic [7:0]  ent_bus;
    logic [7:0]  ent_irq;
    logic [31:0] ent_word;
    logic        walk_stopped;
    // staged and committed results
    logic [15:0] stg_cpus;
    logic [31:0] stg_ioapic;
    logic        stg_found;
    logic        stg_multi;
    logic [7:0]  stg_map [ISA_IRQ_COUNT];
    logic [15:0] cmt_cpus;
    logic [31:0] cmt_ioapic;
    logic        cmt_found;
    logic [7:0]  cmt_map [ISA_IRQ_COUNT];

    madt_table_stream_parser_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    task automatic clear_table_walk();
        tbl_offset   = '0;
        tbl_sum      = '0;
        sig_ok       = 1'b1;
        tbl_len      = '0;
        ent_start    = MADT_HEADER_BYTES;
        ent_type     = '0;
        ent_len      = '0;
        ent_bus      = '0;
        ent_irq      = '0;
        ent_word     = '0;
        walk_stopped = 1'b0;
    endtask

    task automatic reset_parser_model();
        clear_table_walk();
        stg_cpus   = '0;
        stg_ioapic = '0;
        stg_found  = 1'b0;
        stg_multi  = 1'b0;
        cmt_cpus   = '0;
        cmt_ioapic = '0;
        cmt_found  = 1'b0;
        for (int i = 0; i < ISA_IRQ_COUNT; i++) begin
            stg_map[i] = 8'(i);
            cmt_map[i] = 8'(i);
        end
    endtask

    task automatic advance_madt_parser(input t_in_item beat, output t_out_item res);
        logic [7:0]  b;
        logic [31:0] off;
        logic [31:0] rel;
        logic [32:0] next_start;
        logic        done;
        res  = '0;
        done = 1'b0;
        if (beat.cmd == CMD_LOOKUP) begin
            res.mapped_vector = cmt_map[beat.isa_irq];
        end else begin
            b   = beat.data_byte;
            off = tbl_offset;
            if (off == 0) begin
                stg_cpus   = cmt_cpus;
                stg_ioapic = cmt_ioapic;
                stg_found  = cmt_found;
                for (int i = 0; i < ISA_IRQ_COUNT; i++) stg_map[i] = cmt_map[i];
            end
            tbl_sum = tbl_sum + b;
            if (off < 4) begin
                if (b != MADT_SIG[31 - 8 * off -: 8]) sig_ok = 1'b0;
            end else if (off < 8) begin
                tbl_len = tbl_len | (32'(b) << (8 * (off - 4)));
            end
            if (!walk_stopped && off >= MADT_HEADER_BYTES && off >= ent_start &&
                ent_start < tbl_len) begin
                rel = off - ent_start;
                if (rel == 0) begin
                    ent_type = b;
                    ent_word = '0;
                end else if (rel == 1 && b < 2) begin
                    ent_len      = b;
                    walk_stopped = 1'b1;
                end else begin
                    if (rel == 1) begin
                        ent_len = b;
                        if (ent_type == TYPE_LOCAL_APIC && stg_cpus != 16'hFFFF)
                            stg_cpus = stg_cpus + 1'b1;
                    end else if (rel == 2) begin
                        ent_bus = b;
                    end else if (rel == 3) begin
                        ent_irq = b;
                    end else if (rel <= 7) begin
                        ent_word = ent_word | (32'(b) << (8 * (rel - 4)));
                        if (rel == 7) begin
                            if (ent_type == TYPE_IO_APIC) begin
                                if (stg_found) begin
                                    stg_multi = 1'b1;
                                end else begin
                                    stg_ioapic = ent_word;
                                    stg_found  = 1'b1;
                                end
                            end else if (ent_type == TYPE_SRC_OVERRIDE) begin
                                if (ent_bus == 0 && ent_irq < ISA_IRQ_COUNT)
                                    stg_map[ent_irq[IRQ_W-1:0]] = ent_word[7:0];
                            end
                        end
                    end
                    if (rel + 32'd1 == 32'(ent_len)) begin
                        next_start = 33'(ent_start) + 33'(ent_len);
                        ent_start  = next_start[32] ? '1 : next_start[31:0];
                    end
                end
            end
            if (tbl_offset != '1) tbl_offset = tbl_offset + 1'b1;
            if (beat.last) begin
                done           = 1'b1;
                res.table_done = 1'b1;
                if (tbl_offset >= 4 && sig_ok && tbl_sum == 0) begin
                    res.table_accepted = 1'b1;
                    cmt_cpus   = stg_cpus;
                    cmt_ioapic = stg_ioapic;
                    cmt_found  = stg_found;
                    for (int i = 0; i < ISA_IRQ_COUNT; i++) cmt_map[i] = stg_map[i];
                end
            end
        end
        res.checksum_ok      = (tbl_sum == 0);
        res.is_madt          = sig_ok;
        res.cpu_count        = cmt_cpus;
        res.ioapic_base      = cmt_ioapic;
        res.ioapic_found     = cmt_found;
        res.multiple_ioapic  = stg_multi;
        res.bad_entry_length = walk_stopped;
        if (done) clear_table_walk();
    endtask

    function automatic t_in_item lookup_beat(input logic [IRQ_W-1:0] vec,
                                             input logic [7:0] junk, input logic lst);
        t_in_item beat;
        beat.cmd       = CMD_LOOKUP;
        beat.data_byte = junk;
        beat.last      = lst;
        beat.isa_irq   = vec;
        return beat;
    endfunction

    task automatic push_random_bytes(input int n);
        repeat (n) madt_bytes.push_back(8'($urandom));
    endtask

    function automatic t_entry_kind random_entry_kind();
        t_entry_kind kind;
        case ($urandom_range(0, 9))
            0, 1, 2: kind = ENT_LOCAL_APIC;
            3, 4:    kind = ENT_IO_APIC;
            5, 6:    kind = ENT_OVR_ISA;
            7:       kind = ENT_OVR_HIGH_IRQ;
            8:       kind = ENT_OVR_OTHER_BUS;
            default: kind = $urandom_range(0, 1) ? ENT_SHORT : ENT_OTHER_TYPE;
        endcase
        return kind;
    endfunction

    task automatic append_madt_entry(input t_entry_kind kind);
        int n;
        case (kind)
            ENT_LOCAL_APIC: begin
                madt_bytes.push_back(TYPE_LOCAL_APIC);
                madt_bytes.push_back(8'(LAPIC_LEN));
                push_random_bytes(LAPIC_LEN - 2);
            end
            ENT_IO_APIC: begin
                madt_bytes.push_back(TYPE_IO_APIC);
                madt_bytes.push_back(8'(IOAPIC_LEN));
                push_random_bytes(IOAPIC_LEN - 2);
            end
            ENT_OVR_ISA, ENT_OVR_HIGH_IRQ, ENT_OVR_OTHER_BUS: begin
                madt_bytes.push_back(TYPE_SRC_OVERRIDE);
                madt_bytes.push_back(8'(OVR_LEN));
                madt_bytes.push_back(kind == ENT_OVR_OTHER_BUS ?
                                     8'($urandom_range(1, 255)) : 8'h00);
                madt_bytes.push_back(kind == ENT_OVR_HIGH_IRQ ?
                                     8'($urandom_range(ISA_IRQ_COUNT, 255)) :
                                     8'($urandom_range(0, ISA_IRQ_COUNT - 1)));
                push_random_bytes(OVR_LEN - 4);
            end
            ENT_SHORT: begin
                n = $urandom_range(2, 7);
                madt_bytes.push_back(8'($urandom_range(TYPE_LOCAL_APIC, TYPE_SRC_OVERRIDE)));
                madt_bytes.push_back(8'(n));
                push_random_bytes(n - 2);
            end
            ENT_OTHER_TYPE: begin
                n = $urandom_range(2, 16);
                madt_bytes.push_back(8'($urandom_range(TYPE_SRC_OVERRIDE + 1, 255)));
                madt_bytes.push_back(8'(n));
                push_random_bytes(n - 2);
            end
            default: begin
                madt_bytes.push_back(8'($urandom));
                madt_bytes.push_back(8'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic emit_madt_bytes();
        t_in_item beat;
        foreach (madt_bytes[k]) begin
            if ($urandom_range(0, 99) < 4)
                beat_backlog.push_back(lookup_beat(IRQ_W'($urandom), 8'($urandom),
                                                   1'($urandom)));
            beat.cmd       = CMD_TABLE_BYTE;
            beat.data_byte = madt_bytes[k];
            beat.last      = (k == madt_bytes.size() - 1);
            beat.isa_irq   = IRQ_W'($urandom);
            beat_backlog.push_back(beat);
        end
    endtask

    task automatic queue_madt_table(input t_table_flavor flavor);
        int         n_entries;
        int         bad_at;
        int         len_field;
        logic [7:0] sum;
        madt_bytes.delete();
        if (flavor == TBL_NOISE) begin
            push_random_bytes($urandom_range(1, 60));
        end else begin
            for (int k = 0; k < 4; k++) madt_bytes.push_back(MADT_SIG[31 - 8 * k -: 8]);
            push_random_bytes(MADT_HEADER_BYTES - 4);
            if (flavor == TBL_EVERY_ENTRY) begin
                for (int k = ENT_LOCAL_APIC; k <= ENT_OTHER_TYPE; k++)
                    append_madt_entry(t_entry_kind'(k));
                append_madt_entry(ENT_IO_APIC);
            end else begin
                n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                                                          $urandom_range(1, 8);
                bad_at = (flavor == TBL_BAD_LENGTH) ? $urandom_range(0, n_entries - 1) : -1;
                for (int k = 0; k < n_entries; k++) begin
                    if (k == bad_at) append_madt_entry(ENT_BAD_LENGTH);
                    append_madt_entry(random_entry_kind());
                end
            end
            len_field = madt_bytes.size();
            if (flavor == TBL_SHORT_LENGTH) len_field = $urandom_range(0, len_field - 1);
            for (int k = 0; k < 4; k++) madt_bytes[4 + k] = 8'(len_field >> (8 * k));
            if (flavor == TBL_BAD_SIG)
                madt_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            if (flavor == TBL_TRAILING) push_random_bytes($urandom_range(1, 20));
            // balance the checksum byte so the whole stream sums to zero
            madt_bytes[9] = 8'h00;
            sum = 8'h00;
            foreach (madt_bytes[k]) sum = sum + madt_bytes[k];
            madt_bytes[9] = -sum;
            if (flavor == TBL_BAD_SUM) madt_bytes[9] = madt_bytes[9] + 8'($urandom_range(1, 255));
            if (flavor == TBL_CUT_SHORT)
                repeat ($urandom_range(1, madt_bytes.size() - 1)) void'(madt_bytes.pop_back());
        end
        emit_madt_bytes();
        repeat ($urandom_range(0, 3))
            beat_backlog.push_back(lookup_beat(IRQ_W'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // driver: predict accepted beats, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                advance_madt_parser(i_item, next_result);
                parser_results.push_back(next_result);
            end
            if (!i_valid || o_ready) begin
                if (beat_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_item  <= beat_backlog.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (cyc == HOLD_START) begin
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (parser_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'd0, 32'd0);
            end else begin
                want_result = parser_results.pop_front();
                check_field("mapped_vector", 32'(o_result.mapped_vector),
                            32'(want_result.mapped_vector));
                check_field("table_done", 32'(o_result.table_done),
                            32'(want_result.table_done));
                check_field("table_accepted", 32'(o_result.table_accepted),
                            32'(want_result.table_accepted));
                check_field("checksum_ok", 32'(o_result.checksum_ok),
                            32'(want_result.checksum_ok));
                check_field("is_madt", 32'(o_result.is_madt), 32'(want_result.is_madt));
                check_field("cpu_count", 32'(o_result.cpu_count),
                            32'(want_result.cpu_count));
                check_field("ioapic_base", o_result.ioapic_base, want_result.ioapic_base);
                check_field("ioapic_found", 32'(o_result.ioapic_found),
                            32'(want_result.ioapic_found));
                check_field("multiple_ioapic", 32'(o_result.multiple_ioapic),
                            32'(want_result.multiple_ioapic));
                check_field("bad_entry_length", 32'(o_result.bad_entry_length),
                            32'(want_result.bad_entry_length));
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cyc <= cyc + 1;
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int            n_table;
        int            r;
        logic [7:0]    sum;
        t_table_flavor flavor;
        reset_parser_model();
        for (int v = 0; v < ISA_IRQ_COUNT; v++)
            beat_backlog.push_back(lookup_beat(IRQ_W'(v), v[0] ? 8'hFF : 8'h00, v[1]));
        // one-byte table, bare signature, and the smallest table that commits
        madt_bytes.delete();
        madt_bytes.push_back(MADT_SIG[31:24]);
        emit_madt_bytes();
        madt_bytes.delete();
        for (int k = 0; k < 4; k++) madt_bytes.push_back(MADT_SIG[31 - 8 * k -: 8]);
        emit_madt_bytes();
        sum = 8'h00;
        foreach (madt_bytes[k]) sum = sum + madt_bytes[k];
        madt_bytes.push_back(-sum);
        emit_madt_bytes();
        n_table = 0;
        while (beat_backlog.size() < RANDOM_BEATS + 25) begin
            if (n_table < NUM_FLAVORS) begin
                flavor = t_table_flavor'(n_table);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55)      flavor = TBL_CLEAN;
                else if (r < 62) flavor = TBL_EVERY_ENTRY;
                else             flavor = t_table_flavor'($urandom_range(TBL_BAD_SUM, TBL_NOISE));
            end
            queue_madt_table(flavor);
            n_table++;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (beat_backlog.size() != 0 || i_valid || parser_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: madt_table_stream_parser_unit.f
rtl/mtsp_pkg.sv
rtl/mtsp_in_stage.sv
rtl/mtsp_table_walker.sv
rtl/mtsp_result_store.sv
rtl/madt_table_stream_parser_unit.sv
test/madt_table_stream_parser_unit_tb.sv
